[rtl/rmd_pkg.sv]
// rmd_pkg: shared constants and payload types of the rectangle move redraw block
// no dependencies; used by rmd_chan_if users and rect_move_delta_redraw
package rmd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam int SCREEN_BITS = 12;
   localparam int BOX_POS_BITS = 11;
   localparam int BOX_SIZE_BITS = 12;
   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_INDEX_BITS = 3;

   localparam int N_FILLS = 6;
   localparam int FILL_IDX_BITS = $clog2(N_FILLS);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_LEFT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_TOP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_WIDTH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_HEIGHT = 3'd5;

   // reset values
   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET = 12'd480;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd320;
   localparam logic [BOX_POS_BITS-1:0] BOX_LEFT_RESET = 11'd0;
   localparam logic [BOX_POS_BITS-1:0] BOX_TOP_RESET = 11'd0;
   localparam logic [BOX_SIZE_BITS-1:0] BOX_WIDTH_RESET = 12'd480;
   localparam logic [BOX_SIZE_BITS-1:0] BOX_HEIGHT_RESET = 12'd320;

   typedef struct packed {
      logic signed [15:0] old_x;
      logic signed [15:0] old_y;
      logic signed [15:0] new_x;
      logic signed [15:0] new_y;
      logic [14:0]        rect_width;
      logic [14:0]        rect_height;
      logic [15:0]        fore_color;
      logic [15:0]        back_color;
   } req_payload_type;

   typedef struct packed {
      logic [10:0] fill_x;
      logic [10:0] fill_y;
      logic [11:0] fill_w;
      logic [11:0] fill_h;
      logic [15:0] fill_color;
      logic        is_erase;
      logic        last;
   } rsp_payload_type;

endpackage

[rtl/rmd_chan_if.sv]
// rmd_chan_if: valid/ready channel carrying one payload per request
// generic in the payload type; no package dependency
interface rmd_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/rect_move_delta_redraw.sv]
// rect_move_delta_redraw: clipped rectangle move with delta redraw, four-stage pipeline
// depends on rmd_pkg (constants, payload types) and rmd_chan_if (channels)
//
// Usage
//   req_chan takes one move request: old and new corner, size, outline and
//   background colors. rsp_chan returns up to six fill commands for it, in
//   order: two erase strips, then top, bottom, left and right outline
//   segments; empty ones are skipped and the final one carries last.
//   A move that yields no fill produces nothing on rsp_chan.
//   csr_we/csr_index/csr_wdata write the screen and border box registers;
//   write them only while no request is in flight.
// Timing
//   Requests pass three compute stages and an output stage that holds all
//   fills of one request; the first fill is offered once the request reaches
//   the output stage, which sends one fill a cycle while rsp_chan.ready is
//   high and takes the next request as the last fill is accepted.
//   A new request is taken every cycle while the output stage keeps up.
// Reset and stalls
//   Reset empties the pipeline and loads the default screen and box. When
//   rsp_chan stalls, the stages fill up and then req_chan.ready drops; no
//   request or fill is dropped or sent twice.
module rect_move_delta_redraw #(
   parameter int COORD_BITS = rmd_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rmd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rmd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   rmd_chan_if.sink                           req_chan,
   rmd_chan_if.source                         rsp_chan
);
   import rmd_pkg::*;

   localparam int CW = COORD_BITS;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [CW+1:0] wide_type;

   typedef struct packed {
      logic      en;
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } strip_type;

   typedef struct packed {
      coord_type   ox;
      coord_type   oy;
      coord_type   nx;
      coord_type   ny;
      coord_type   iw;
      coord_type   ih;
      coord_type   dx;
      coord_type   dy;
      coord_type   adx;
      coord_type   ady;
      coord_type   hix;
      coord_type   hiy;
      logic [15:0] fg;
      logic [15:0] bg;
   } s1_type;

   typedef struct packed {
      strip_type   ea;
      strip_type   eb;
      coord_type   cx;
      coord_type   cy;
      coord_type   iw;
      coord_type   ih;
      logic [15:0] fg;
      logic [15:0] bg;
   } s2_type;

   typedef struct packed {
      strip_type   ea;
      strip_type   eb;
      logic        hen;
      coord_type   hx;
      coord_type   hlen;
      logic        ven;
      coord_type   vy;
      coord_type   vlen;
      coord_type   cx;
      coord_type   cy;
      coord_type   x2;
      coord_type   y2;
      logic [15:0] fg;
      logic [15:0] bg;
   } s3_type;

   function automatic coord_type wrap_c(input wide_type v);
      return coord_type'(v[CW-1:0]);
   endfunction

   function automatic wide_type ext(input coord_type v);
      return wide_type'(v);
   endfunction

   function automatic logic is_pos(input coord_type v);
      return !v[CW-1] && (v != '0);
   endfunction

   // drop empty strips and cut off the part left of or above the screen
   function automatic strip_type strip_pre(input strip_type s);
      strip_type r;
      r = s;
      r.en = s.en && is_pos(s.w) && is_pos(s.h);
      if (s.x[CW-1]) begin
         r.w = wrap_c(ext(s.w) + ext(s.x));
         r.x = '0;
      end
      if (s.y[CW-1]) begin
         r.h = wrap_c(ext(s.h) + ext(s.y));
         r.y = '0;
      end
      return r;
   endfunction

   function automatic logic strip_fin(input strip_type s, input logic [SCREEN_BITS-1:0] xs,
                                      input logic [SCREEN_BITS-1:0] ys,
                                      output coord_type w2, output coord_type h2);
      logic ok;
      ok = s.en && (ext(s.x) < wide_type'(xs)) && (ext(s.y) < wide_type'(ys));
      w2 = (ext(s.x) + ext(s.w) > wide_type'(xs)) ? wrap_c(wide_type'(xs) - ext(s.x)) : s.w;
      h2 = (ext(s.y) + ext(s.h) > wide_type'(ys)) ? wrap_c(wide_type'(ys) - ext(s.y)) : s.h;
      return ok && is_pos(w2) && is_pos(h2);
   endfunction

   // one-pixel segment: across is the fixed coordinate, along the clipped one
   function automatic logic seg_fin(input logic en, input coord_type across,
                                    input logic [SCREEN_BITS-1:0] lim_across,
                                    input coord_type along, input coord_type len,
                                    input logic [SCREEN_BITS-1:0] lim_along,
                                    output coord_type len2);
      logic ok;
      ok = en && !across[CW-1] && (ext(across) < wide_type'(lim_across));
      len2 = (ext(along) + ext(len) > wide_type'(lim_along)) ?
             wrap_c(wide_type'(lim_along) - ext(along)) : len;
      return ok && is_pos(len2);
   endfunction

   // configuration registers
   logic [SCREEN_BITS-1:0]   screen_width_ff;
   logic [SCREEN_BITS-1:0]   screen_height_ff;
   logic [BOX_POS_BITS-1:0]  box_left_ff;
   logic [BOX_POS_BITS-1:0]  box_top_ff;
   logic [BOX_SIZE_BITS-1:0] box_width_ff;
   logic [BOX_SIZE_BITS-1:0] box_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         box_left_ff <= BOX_LEFT_RESET;
         box_top_ff <= BOX_TOP_RESET;
         box_width_ff <= BOX_WIDTH_RESET;
         box_height_ff <= BOX_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: begin
               screen_width_ff <= csr_wdata[SCREEN_BITS-1:0];
            end
            CSR_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_wdata[SCREEN_BITS-1:0];
            end
            CSR_BOX_LEFT: begin
               box_left_ff <= csr_wdata[BOX_POS_BITS-1:0];
            end
            CSR_BOX_TOP: begin
               box_top_ff <= csr_wdata[BOX_POS_BITS-1:0];
            end
            CSR_BOX_WIDTH: begin
               box_width_ff <= csr_wdata[BOX_SIZE_BITS-1:0];
            end
            CSR_BOX_HEIGHT: begin
               box_height_ff <= csr_wdata[BOX_SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   logic s1_v_ff, s2_v_ff, s3_v_ff;
   logic ready1, ready2, ready3, ready4;
   logic [N_FILLS-1:0] mask_ff, mask_in, mask_rest;

   assign mask_rest = mask_ff & (mask_ff - N_FILLS'(1));
   assign ready4 = (mask_ff == '0) || (rsp_chan.ready && (mask_rest == '0));
   assign ready3 = !s3_v_ff || ready4;
   assign ready2 = !s2_v_ff || ready3;
   assign ready1 = !s1_v_ff || ready2;
   assign req_chan.ready = ready1;

   // stage 1: wrap inputs, deltas, clamp upper bounds
   s1_type s1_ff, s1_in;
   logic [15:0] rw_ext, rh_ext;

   always_comb begin
      rw_ext = {1'b0, req_chan.payload.rect_width};
      rh_ext = {1'b0, req_chan.payload.rect_height};
      s1_in.ox = coord_type'(req_chan.payload.old_x[CW-1:0]);
      s1_in.oy = coord_type'(req_chan.payload.old_y[CW-1:0]);
      s1_in.nx = coord_type'(req_chan.payload.new_x[CW-1:0]);
      s1_in.ny = coord_type'(req_chan.payload.new_y[CW-1:0]);
      s1_in.iw = coord_type'(rw_ext[CW-1:0]);
      s1_in.ih = coord_type'(rh_ext[CW-1:0]);
      s1_in.dx = wrap_c(ext(s1_in.nx) - ext(s1_in.ox));
      s1_in.dy = wrap_c(ext(s1_in.ny) - ext(s1_in.oy));
      s1_in.adx = s1_in.dx[CW-1] ? wrap_c(-ext(s1_in.dx)) : s1_in.dx;
      s1_in.ady = s1_in.dy[CW-1] ? wrap_c(-ext(s1_in.dy)) : s1_in.dy;
      s1_in.hix = wrap_c(wide_type'(box_left_ff) + wide_type'(box_width_ff) - ext(s1_in.iw));
      s1_in.hiy = wrap_c(wide_type'(box_top_ff) + wide_type'(box_height_ff) - ext(s1_in.ih));
      s1_in.fg = req_chan.payload.fore_color;
      s1_in.bg = req_chan.payload.back_color;
   end

   // stage 2: erase strip geometry, clamped corner
   s2_type s2_ff, s2_in;
   logic dx_pos, dy_pos;

   always_comb begin
      dx_pos = is_pos(s1_ff.dx);
      dy_pos = is_pos(s1_ff.dy);
      s2_in.ea.en = (s1_ff.dx != '0);
      s2_in.ea.x = dx_pos ? s1_ff.ox :
                   wrap_c(ext(s1_ff.ox) + ext(s1_ff.iw) - ext(s1_ff.adx));
      s2_in.ea.y = !s1_ff.dy[CW-1] ? s1_ff.oy : wrap_c(ext(s1_ff.oy) + ext(s1_ff.dy));
      s2_in.ea.w = s1_ff.adx;
      s2_in.ea.h = wrap_c(ext(s1_ff.ih) + ext(s1_ff.ady));
      s2_in.eb.en = (s1_ff.dy != '0);
      s2_in.eb.x = !s1_ff.dx[CW-1] ? wrap_c(ext(s1_ff.ox) + ext(s1_ff.adx)) : s1_ff.ox;
      s2_in.eb.y = dy_pos ? s1_ff.oy :
                   wrap_c(ext(s1_ff.oy) + ext(s1_ff.ih) - ext(s1_ff.ady));
      s2_in.eb.w = wrap_c(ext(s1_ff.iw) - ext(s1_ff.adx));
      s2_in.eb.h = s1_ff.ady;
      if (ext(s1_ff.nx) < wide_type'(box_left_ff)) begin
         s2_in.cx = coord_type'(box_left_ff);
      end else if (s1_ff.nx > s1_ff.hix) begin
         s2_in.cx = s1_ff.hix;
      end else begin
         s2_in.cx = s1_ff.nx;
      end
      if (ext(s1_ff.ny) < wide_type'(box_top_ff)) begin
         s2_in.cy = coord_type'(box_top_ff);
      end else if (s1_ff.ny > s1_ff.hiy) begin
         s2_in.cy = s1_ff.hiy;
      end else begin
         s2_in.cy = s1_ff.ny;
      end
      s2_in.iw = s1_ff.iw;
      s2_in.ih = s1_ff.ih;
      s2_in.fg = s1_ff.fg;
      s2_in.bg = s1_ff.bg;
   end

   // stage 3: far edges of the outline, clip at the top-left screen border
   s3_type s3_ff, s3_in;

   always_comb begin
      s3_in.ea = strip_pre(s2_ff.ea);
      s3_in.eb = strip_pre(s2_ff.eb);
      s3_in.hen = is_pos(s2_ff.iw);
      s3_in.hx = s2_ff.cx[CW-1] ? coord_type'('0) : s2_ff.cx;
      s3_in.hlen = s2_ff.cx[CW-1] ? wrap_c(ext(s2_ff.iw) + ext(s2_ff.cx)) : s2_ff.iw;
      s3_in.ven = is_pos(s2_ff.ih);
      s3_in.vy = s2_ff.cy[CW-1] ? coord_type'('0) : s2_ff.cy;
      s3_in.vlen = s2_ff.cy[CW-1] ? wrap_c(ext(s2_ff.ih) + ext(s2_ff.cy)) : s2_ff.ih;
      s3_in.cx = s2_ff.cx;
      s3_in.cy = s2_ff.cy;
      s3_in.x2 = wrap_c(ext(s2_ff.cx) + ext(s2_ff.iw) - wide_type'(1));
      s3_in.y2 = wrap_c(ext(s2_ff.cy) + ext(s2_ff.ih) - wide_type'(1));
      s3_in.fg = s2_ff.fg;
      s3_in.bg = s2_ff.bg;
   end

   // stage 4: final clip against the screen, build the fill commands
   rsp_payload_type cmd_ff [N_FILLS];
   rsp_payload_type cmd_in [N_FILLS];
   coord_type wa, ha, wb, hb, lt, lb, ll, lr;

   always_comb begin
      mask_in[0] = strip_fin(s3_ff.ea, screen_width_ff, screen_height_ff, wa, ha);
      mask_in[1] = strip_fin(s3_ff.eb, screen_width_ff, screen_height_ff, wb, hb);
      mask_in[2] = seg_fin(s3_ff.hen, s3_ff.cy, screen_height_ff, s3_ff.hx, s3_ff.hlen,
                           screen_width_ff, lt);
      mask_in[3] = seg_fin(s3_ff.hen, s3_ff.y2, screen_height_ff, s3_ff.hx, s3_ff.hlen,
                           screen_width_ff, lb);
      mask_in[4] = seg_fin(s3_ff.ven, s3_ff.cx, screen_width_ff, s3_ff.vy, s3_ff.vlen,
                           screen_height_ff, ll);
      mask_in[5] = seg_fin(s3_ff.ven, s3_ff.x2, screen_width_ff, s3_ff.vy, s3_ff.vlen,
                           screen_height_ff, lr);

      cmd_in[0] = '{fill_x: s3_ff.ea.x[10:0], fill_y: s3_ff.ea.y[10:0],
                    fill_w: wa[11:0], fill_h: ha[11:0],
                    fill_color: s3_ff.bg, is_erase: 1'b1, last: 1'b0};
      cmd_in[1] = '{fill_x: s3_ff.eb.x[10:0], fill_y: s3_ff.eb.y[10:0],
                    fill_w: wb[11:0], fill_h: hb[11:0],
                    fill_color: s3_ff.bg, is_erase: 1'b1, last: 1'b0};
      cmd_in[2] = '{fill_x: s3_ff.hx[10:0], fill_y: s3_ff.cy[10:0],
                    fill_w: lt[11:0], fill_h: 12'd1,
                    fill_color: s3_ff.fg, is_erase: 1'b0, last: 1'b0};
      cmd_in[3] = '{fill_x: s3_ff.hx[10:0], fill_y: s3_ff.y2[10:0],
                    fill_w: lb[11:0], fill_h: 12'd1,
                    fill_color: s3_ff.fg, is_erase: 1'b0, last: 1'b0};
      cmd_in[4] = '{fill_x: s3_ff.cx[10:0], fill_y: s3_ff.vy[10:0],
                    fill_w: 12'd1, fill_h: ll[11:0],
                    fill_color: s3_ff.fg, is_erase: 1'b0, last: 1'b0};
      cmd_in[5] = '{fill_x: s3_ff.x2[10:0], fill_y: s3_ff.vy[10:0],
                    fill_w: 12'd1, fill_h: lr[11:0],
                    fill_color: s3_ff.fg, is_erase: 1'b0, last: 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         mask_ff <= '0;
      end else begin
         if (ready1) begin
            s1_v_ff <= req_chan.valid;
         end
         if (ready2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (ready3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (ready4) begin
            mask_ff <= s3_v_ff ? mask_in : '0;
         end else if (rsp_chan.ready) begin
            mask_ff <= mask_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_ff <= s1_in;
      end
      if (ready2) begin
         s2_ff <= s2_in;
      end
      if (ready3) begin
         s3_ff <= s3_in;
      end
      if (ready4) begin
         cmd_ff <= cmd_in;
      end
   end

   // send the lowest pending fill
   logic [FILL_IDX_BITS-1:0] sel_idx;
   logic                     found;

   always_comb begin
      sel_idx = '0;
      found = 1'b0;
      for (int i = 0; i < N_FILLS; i++) begin
         if (mask_ff[i] && !found) begin
            sel_idx = FILL_IDX_BITS'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_chan.valid = (mask_ff != '0);
      rsp_chan.payload = cmd_ff[sel_idx];
      rsp_chan.payload.last = (mask_rest == '0);
   end

endmodule
